>>> rtl/core/qkad_pkg.sv
// Shared types, codes and exponent tables for the quantized KV attention decode block.
// No dependencies; imported by quantized_kv_attention_decode.
package qkad_pkg;

    // command codes carried on s_command
    typedef enum logic [2:0] {
        CMD_LOAD_CENTROID = 3'd0,
        CMD_LOAD_QUERY    = 3'd1,
        CMD_START         = 3'd2,
        CMD_KV_ELEM       = 3'd3,
        CMD_READ_OUT      = 3'd4
    } cmd_t;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_DIM    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_SCALE = 2'd2;

    localparam logic [7:0]  HEAD_DIM_RST    = 8'd128;
    localparam logic [15:0] SCORE_SCALE_RST = 16'd5793;

    // datapath widths
    localparam int DOT_W   = 48;
    localparam int WIDE_W  = 64;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int EXP_W   = 17;
    localparam int DIFF_W  = 33;
    localparam int VAL_W   = 25;
    localparam int DIV_W   = 48;
    localparam logic [16:0] EXP_NMAX = 17'd12;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_K_MUL,
        ST_K_ACC,
        ST_FIN,
        ST_W_LO,
        ST_W_HI,
        ST_W_SUM,
        ST_MAX,
        ST_E1,
        ST_E2,
        ST_E3,
        ST_SUM,
        ST_SUM2,
        ST_L_RD,
        ST_L_V,
        ST_L_A,
        ST_L_B,
        ST_L_C,
        ST_R_RD,
        ST_DIV,
        ST_DSAT,
        ST_R_OUT
    } state_t;

    // exp(-n), Q1.16
    function automatic logic [EXP_W-1:0] exp_int_lut(input logic [3:0] n);
        logic [EXP_W-1:0] v;
        case (n)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // exp(-k/16), Q1.16
    function automatic logic [EXP_W-1:0] exp_frac_lut(input logic [3:0] k);
        logic [EXP_W-1:0] v;
        case (k)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd61565;
            4'd2:    v = 17'd57836;
            4'd3:    v = 17'd54331;
            4'd4:    v = 17'd51039;
            4'd5:    v = 17'd47947;
            4'd6:    v = 17'd45042;
            4'd7:    v = 17'd42313;
            4'd8:    v = 17'd39750;
            4'd9:    v = 17'd37341;
            4'd10:   v = 17'd35079;
            4'd11:   v = 17'd32954;
            4'd12:   v = 17'd30957;
            4'd13:   v = 17'd29081;
            4'd14:   v = 17'd27319;
            4'd15:   v = 17'd25664;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/quantized_kv_attention_decode.sv
// Top level of the quantized KV attention decode block (online softmax, one head).
// Depends on qkad_pkg and qkad_ram.
//
// One query head is decoded over a streamed key/value cache. Load the centroid table
// and the query first, issue a start, then stream each position one element per word;
// the element at index head_dim-1 closes the position and folds it into the running
// max, sum and per-dimension accumulators. A read word returns acc/sum in Q16.16.
// Flow, one word at a time through a single shared 34x18 multiplier: load, start
// and ignored words are taken in idle; a key/value element passes K_MUL and K_ACC;
// closing a position adds the score, max, exponent and sum steps, then per accumulator
// the read, value, rescale, weight and write steps; a read runs the 48-step restoring
// divider, or skips it when the result is empty. A finished read word sits in the
// output register while the next input word is taken. No clearing pass after reset:
// accumulator entries carry valid bits that a start clears at once.
module quantized_kv_attention_decode #(
    parameter int MAX_HEAD_DIM = 128,
    parameter int CENTROIDS    = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_we,
    input  logic [qkad_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [qkad_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input words
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [2:0]                        s_command,
    input  logic [6:0]                        s_index,
    input  logic signed [15:0]                s_data,
    input  logic [7:0]                        s_key_code,
    input  logic [7:0]                        s_value_code,
    input  logic [15:0]                       s_key_norm,
    input  logic signed [15:0]                s_value_scale,
    input  logic signed [15:0]                s_value_zero,
    // result words
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [6:0]                        m_out_index,
    output logic signed [31:0]                m_out_value,
    output logic                              m_empty_res
);
    import qkad_pkg::*;

    localparam int AW        = $clog2(MAX_HEAD_DIM);
    localparam int CW        = $clog2(CENTROIDS);
    localparam int DIM_LIM   = (MAX_HEAD_DIM < 128) ? MAX_HEAD_DIM : 128;
    localparam int KMOD_RCP  = (65536 + CENTROIDS - 1) / CENTROIDS;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // ---------------------------------------------------------------- state
    state_t state_reg, state_next;

    logic                      key_mode_reg;
    logic [7:0]                head_dim_reg;
    logic [15:0]               score_scale_reg;

    logic [6:0]                idx_reg;
    logic signed [15:0]        data_reg;
    logic [15:0]               norm_reg;
    logic signed [15:0]        vs_reg;
    logic signed [15:0]        vz_reg;

    logic signed [DOT_W-1:0]   dot_reg;
    logic signed [DOT_W-1:0]   x_reg;       // operand of the wide x*16u multiply
    logic signed [WIDE_W-1:0]  wacc_reg;
    logic                      wph_reg;     // 0: x*norm, 1: t*score_scale
    logic signed [MUL_P_W-1:0] prod_reg;
    logic signed [31:0]        score_reg;
    logic signed [31:0]        mnew_reg;
    logic signed [31:0]        run_max_reg;
    logic signed [31:0]        run_sum_reg;
    logic                      seen_reg;
    logic [DIFF_W-1:0]         ex_reg;      // exponent argument, negated
    logic                      eph_reg;     // 0: rescale factor, 1: position weight
    logic [EXP_W-1:0]          e_reg;
    logic [EXP_W-1:0]          re_reg;
    logic [EXP_W-1:0]          p_reg;
    logic signed [VAL_W-1:0]   v_reg;
    logic signed [32:0]        a1_reg;
    logic [7:0]                cnt_reg;
    logic [MAX_HEAD_DIM-1:0]   acc_vld_reg;
    logic                      acc_vld_q_reg;

    logic [32:0]               div_rem_reg;
    logic [DIV_W-1:0]          div_quo_reg;
    logic [5:0]                div_cnt_reg;
    logic                      div_neg_reg;
    logic signed [31:0]        res_reg;

    logic                      m_valid_reg;
    logic [6:0]                m_out_index_reg;
    logic signed [31:0]        m_out_value_reg;
    logic                      m_empty_res_reg;

    // ---------------------------------------------------------------- decode
    logic [7:0]  dim;
    logic [8:0]  idx_ext;
    logic        s_fire;
    logic        in_dim;
    logic        idx_last;
    logic        cent_ok;
    logic        query_ok;
    logic        kv_go;
    logic        rd_go;
    logic [24:0] kmul;
    logic [17:0] kqc;
    logic [17:0] krem;

    always_comb begin
        if (head_dim_reg == 8'd0) begin
            dim = 8'd1;
        end else if (head_dim_reg > 8'(DIM_LIM)) begin
            dim = 8'(DIM_LIM);
        end else begin
            dim = head_dim_reg;
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign idx_ext  = {2'b00, s_index};
    assign in_dim   = ({1'b0, s_index} < dim);
    assign idx_last = ({1'b0, idx_reg} == (dim - 8'd1));
    assign cent_ok  = (idx_ext < 9'(CENTROIDS));
    assign query_ok = (idx_ext < 9'(MAX_HEAD_DIM));
    assign kv_go    = s_fire && (s_command == CMD_KV_ELEM) && in_dim;
    assign rd_go    = s_fire && (s_command == CMD_READ_OUT) && in_dim;

    // key_code mod CENTROIDS by reciprocal multiply, exact for 8-bit codes
    assign kmul = 25'(s_key_code) * 25'(KMOD_RCP);
    assign kqc  = 18'(kmul[24:16]) * 18'(CENTROIDS);
    assign krem = 18'(s_key_code) - kqc;

    // ---------------------------------------------------------------- memories
    logic                 cen_we, cen_re;
    logic [CW-1:0]        cen_raddr;
    logic [15:0]          cen_rdata;
    logic                 qry_we;
    logic [15:0]          qry_rdata;
    logic                 vbf_re;
    logic [7:0]           vbf_rdata;
    logic                 acc_re, acc_we;
    logic [AW-1:0]        acc_raddr;
    logic [31:0]          acc_rdata;
    logic signed [31:0]   acc_new;

    assign cen_we    = s_fire && (s_command == CMD_LOAD_CENTROID) && cent_ok;
    assign cen_re    = kv_go;
    assign cen_raddr = krem[CW-1:0];
    assign qry_we    = s_fire && (s_command == CMD_LOAD_QUERY) && query_ok;
    assign vbf_re    = (state_reg == ST_L_RD);
    assign acc_re    = rd_go || (state_reg == ST_L_RD);
    assign acc_raddr = rd_go ? idx_ext[AW-1:0] : cnt_reg[AW-1:0];
    assign acc_we    = (state_reg == ST_L_C);

    qkad_ram #(.WIDTH(16), .DEPTH(CENTROIDS)) u_cen_ram (
        .aclk    (aclk),
        .wr_en   (cen_we),
        .wr_addr (idx_ext[CW-1:0]),
        .wr_data (s_data),
        .rd_en   (cen_re),
        .rd_addr (cen_raddr),
        .rd_data (cen_rdata)
    );

    qkad_ram #(.WIDTH(16), .DEPTH(MAX_HEAD_DIM)) u_qry_ram (
        .aclk    (aclk),
        .wr_en   (qry_we),
        .wr_addr (idx_ext[AW-1:0]),
        .wr_data (s_data),
        .rd_en   (kv_go),
        .rd_addr (idx_ext[AW-1:0]),
        .rd_data (qry_rdata)
    );

    qkad_ram #(.WIDTH(8), .DEPTH(MAX_HEAD_DIM)) u_vbf_ram (
        .aclk    (aclk),
        .wr_en   (kv_go),
        .wr_addr (idx_ext[AW-1:0]),
        .wr_data (s_value_code),
        .rd_en   (vbf_re),
        .rd_addr (cnt_reg[AW-1:0]),
        .rd_data (vbf_rdata)
    );

    qkad_ram #(.WIDTH(32), .DEPTH(MAX_HEAD_DIM)) u_acc_ram (
        .aclk    (aclk),
        .wr_en   (acc_we),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (acc_new),
        .rd_en   (acc_re),
        .rd_addr (acc_raddr),
        .rd_data (acc_rdata)
    );

    // an accumulator entry not written since start reads as zero
    logic signed [31:0] acc_eff;
    assign acc_eff = acc_vld_q_reg ? $signed(acc_rdata) : 32'sd0;

    // ---------------------------------------------------------------- shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic [15:0]               wy;
    logic                      e_big;

    assign wy    = wph_reg ? score_scale_reg : norm_reg;
    assign e_big = (ex_reg[32:16] >= EXP_NMAX);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_K_MUL: begin
                mul_a = MUL_A_W'($signed(qry_rdata));
                mul_b = key_mode_reg ? MUL_B_W'(data_reg) : MUL_B_W'($signed(cen_rdata));
            end
            ST_W_LO: begin
                mul_a = $signed({10'b0, x_reg[23:0]});
                mul_b = $signed({2'b0, wy});
            end
            ST_W_HI: begin
                mul_a = MUL_A_W'($signed(x_reg[47:24]));
                mul_b = $signed({2'b0, wy});
            end
            ST_E1: begin
                mul_a = $signed({17'b0, (e_big ? 17'd0 : exp_int_lut(ex_reg[19:16]))});
                mul_b = $signed({1'b0, exp_frac_lut(ex_reg[15:12])});
            end
            ST_E2: begin
                mul_a = $signed({17'b0, prod_reg[32:16]});
                mul_b = $signed({6'b0, ex_reg[11:0]});
            end
            ST_SUM: begin
                mul_a = MUL_A_W'(run_sum_reg);
                mul_b = $signed({1'b0, re_reg});
            end
            ST_L_V: begin
                mul_a = $signed({26'b0, vbf_rdata});
                mul_b = MUL_B_W'(vs_reg);
            end
            ST_L_A: begin
                mul_a = MUL_A_W'(acc_eff);
                mul_b = $signed({1'b0, re_reg});
            end
            ST_L_B: begin
                mul_a = MUL_A_W'(v_reg);
                mul_b = $signed({1'b0, p_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ---------------------------------------------------------------- arithmetic around it
    logic signed [DOT_W:0]    dsum;
    logic signed [DOT_W-1:0]  dot_sat;
    logic signed [WIDE_W-1:0] wsum;
    logic signed [DOT_W-1:0]  wshift;
    logic signed [31:0]       score_sat;
    logic signed [31:0]       mnew;
    logic signed [DIFF_W-1:0] diff_re;
    logic signed [DIFF_W-1:0] diff_p;
    logic signed [DIFF_W-1:0] diff_p_reg;
    logic [EXP_W-1:0]         e_val;
    logic signed [33:0]       ssum;
    logic signed [31:0]       sum_sat;
    logic signed [34:0]       asum;
    logic [31:0]              acc_mag;
    logic [32:0]              div_try;
    logic                     div_ge;
    logic signed [31:0]       div_sat;

    assign dsum = (DOT_W+1)'(dot_reg) + (DOT_W+1)'(prod_reg);
    always_comb begin
        if (dsum[DOT_W] != dsum[DOT_W-1]) begin
            dot_sat = dsum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
        end else begin
            dot_sat = dsum[DOT_W-1:0];
        end
    end

    // low partial sits in wacc, high partial weighs 2^24
    assign wsum   = wacc_reg + (WIDE_W'(prod_reg) <<< 24);
    assign wshift = wsum[WIDE_W-1:16];
    always_comb begin
        if (wshift > 48'(S32_MAX)) begin
            score_sat = S32_MAX;
        end else if (wshift < 48'(S32_MIN)) begin
            score_sat = S32_MIN;
        end else begin
            score_sat = wshift[31:0];
        end
    end

    assign mnew       = (seen_reg && (run_max_reg > score_reg)) ? run_max_reg : score_reg;
    assign diff_re    = DIFF_W'(mnew) - DIFF_W'(run_max_reg);
    assign diff_p     = DIFF_W'(mnew) - DIFF_W'(score_reg);
    assign diff_p_reg = DIFF_W'(mnew_reg) - DIFF_W'(score_reg);
    assign e_val      = e_reg - prod_reg[32:16];

    assign ssum = 34'(prod_reg >>> 16) + $signed({17'b0, p_reg});
    assign sum_sat = (ssum > 34'(S32_MAX)) ? S32_MAX : ssum[31:0];

    assign asum = 35'(a1_reg) + 35'(prod_reg >>> 8);
    always_comb begin
        if (asum > 35'(S32_MAX)) begin
            acc_new = S32_MAX;
        end else if (asum < 35'(S32_MIN)) begin
            acc_new = S32_MIN;
        end else begin
            acc_new = asum[31:0];
        end
    end

    // restoring divider step: remainder stays below the divisor
    assign acc_mag = acc_eff[31] ? 32'(-(33'(acc_eff))) : 32'(acc_eff);
    assign div_try = {div_rem_reg[31:0], div_quo_reg[DIV_W-1]};
    assign div_ge  = (div_try >= {1'b0, run_sum_reg});
    always_comb begin
        if (div_neg_reg) begin
            div_sat = (div_quo_reg > 48'h0000_8000_0000) ? S32_MIN
                    : 32'(-(49'(div_quo_reg)));
        end else begin
            div_sat = (div_quo_reg > 48'h0000_7FFF_FFFF) ? S32_MAX : div_quo_reg[31:0];
        end
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (kv_go) begin
                    state_next = ST_K_MUL;
                end else if (rd_go) begin
                    state_next = ST_R_RD;
                end
            end
            ST_K_MUL: state_next = ST_K_ACC;
            ST_K_ACC: state_next = idx_last ? ST_FIN : ST_IDLE;
            ST_FIN:   state_next = ST_W_LO;
            ST_W_LO:  state_next = ST_W_HI;
            ST_W_HI:  state_next = ST_W_SUM;
            ST_W_SUM: state_next = wph_reg ? ST_MAX : ST_W_LO;
            ST_MAX:   state_next = ST_E1;
            ST_E1:    state_next = ST_E2;
            ST_E2:    state_next = ST_E3;
            ST_E3:    state_next = eph_reg ? ST_SUM : ST_E1;
            ST_SUM:   state_next = ST_SUM2;
            ST_SUM2:  state_next = ST_L_RD;
            ST_L_RD:  state_next = ST_L_V;
            ST_L_V:   state_next = ST_L_A;
            ST_L_A:   state_next = ST_L_B;
            ST_L_B:   state_next = ST_L_C;
            ST_L_C:   state_next = ((cnt_reg + 8'd1) == dim) ? ST_IDLE : ST_L_RD;
            ST_R_RD: begin
                state_next = (seen_reg && (run_sum_reg > 32'sd0)) ? ST_DIV : ST_R_OUT;
            end
            ST_DIV:   state_next = (div_cnt_reg == 6'(DIV_W - 1)) ? ST_DSAT : ST_DIV;
            ST_DSAT:  state_next = ST_R_OUT;
            ST_R_OUT: state_next = out_free ? ST_IDLE : ST_R_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            key_mode_reg    <= 1'b0;
            head_dim_reg    <= HEAD_DIM_RST;
            score_scale_reg <= SCORE_SCALE_RST;
            seen_reg        <= 1'b0;
            run_max_reg     <= S32_MIN;
            run_sum_reg     <= '0;
            dot_reg         <= '0;
            acc_vld_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_KEY_MODE:    key_mode_reg    <= cfg_wdata[0];
                    CFG_HEAD_DIM:    head_dim_reg    <= cfg_wdata[7:0];
                    CFG_SCORE_SCALE: score_scale_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_fire && (s_command == CMD_START)) begin
                acc_vld_reg <= '0;
                seen_reg    <= 1'b0;
                run_max_reg <= S32_MIN;
                run_sum_reg <= '0;
                dot_reg     <= '0;
            end
            if (state_reg == ST_K_ACC) begin
                dot_reg <= dot_sat;
            end
            if (state_reg == ST_SUM2) begin
                run_sum_reg <= sum_sat;
                run_max_reg <= mnew_reg;
                seen_reg    <= 1'b1;
                dot_reg     <= '0;
            end
            if (state_reg == ST_L_C) begin
                acc_vld_reg[cnt_reg[AW-1:0]] <= 1'b1;
            end
            if ((state_reg == ST_R_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- datapath registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            idx_reg  <= s_index;
            data_reg <= s_data;
            norm_reg <= s_key_norm;
            vs_reg   <= s_value_scale;
            vz_reg   <= s_value_zero;
        end
        prod_reg <= mul_p;
        if (acc_re) begin
            acc_vld_q_reg <= acc_vld_reg[acc_raddr];
        end
        case (state_reg)
            ST_FIN: begin
                if (key_mode_reg) begin
                    x_reg   <= dot_reg >>> 8;
                    wph_reg <= 1'b1;
                end else begin
                    x_reg   <= dot_reg;
                    wph_reg <= 1'b0;
                end
            end
            ST_W_HI: wacc_reg <= WIDE_W'(prod_reg);
            ST_W_SUM: begin
                if (!wph_reg) begin
                    x_reg   <= wshift;
                    wph_reg <= 1'b1;
                end else begin
                    score_reg <= score_sat;
                end
            end
            ST_MAX: begin
                mnew_reg <= mnew;
                if (seen_reg) begin
                    ex_reg  <= diff_re;
                    eph_reg <= 1'b0;
                end else begin
                    re_reg  <= '0;
                    ex_reg  <= diff_p;
                    eph_reg <= 1'b1;
                end
            end
            ST_E2: e_reg <= prod_reg[32:16];
            ST_E3: begin
                if (!eph_reg) begin
                    re_reg  <= e_val;
                    ex_reg  <= diff_p_reg;
                    eph_reg <= 1'b1;
                end else begin
                    p_reg <= e_val;
                end
            end
            ST_SUM2: cnt_reg <= '0;
            ST_L_A:  v_reg   <= VAL_W'(prod_reg) + VAL_W'(vz_reg);
            ST_L_B:  a1_reg  <= 33'(prod_reg >>> 16);
            ST_L_C:  cnt_reg <= cnt_reg + 8'd1;
            ST_R_RD: begin
                div_neg_reg <= acc_eff[31];
                div_quo_reg <= {acc_mag, 16'b0};
                div_rem_reg <= '0;
                div_cnt_reg <= '0;
                res_reg     <= '0;
            end
            ST_DIV: begin
                div_rem_reg <= div_ge ? (div_try - {1'b0, run_sum_reg}) : div_try;
                div_quo_reg <= {div_quo_reg[DIV_W-2:0], div_ge};
                div_cnt_reg <= div_cnt_reg + 6'd1;
            end
            ST_DSAT: res_reg <= div_sat;
            ST_R_OUT: begin
                if (out_free) begin
                    m_out_index_reg <= idx_reg;
                    m_out_value_reg <= res_reg;
                    m_empty_res_reg <= !seen_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_out_index = m_out_index_reg;
    assign m_out_value = m_out_value_reg;
    assign m_empty_res = m_empty_res_reg;

endmodule

>>> rtl/core/qkad_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qkad_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [WIDTH-1:0]           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> tb/qkad_checker.sv
// Checker for quantized_kv_attention_decode: watches the config port and both
// word channels, predicts each read word and compares it. Depends on qkad_pkg.
module qkad_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [2:0]         s_command,
    input  logic [6:0]         s_index,
    input  logic signed [15:0] s_data,
    input  logic [7:0]         s_key_code,
    input  logic [7:0]         s_value_code,
    input  logic [15:0]        s_key_norm,
    input  logic signed [15:0] s_value_scale,
    input  logic signed [15:0] s_value_zero,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [6:0]         m_out_index,
    input  logic signed [31:0] m_out_value,
    input  logic               m_empty_res,
    output int                 fail_count,
    output int                 pending
);
    import qkad_pkg::*;

    typedef struct packed {
        logic [6:0]         idx;
        logic signed [31:0] val;
        logic               empty;
    } read_word_t;

    read_word_t read_q[$];

    logic signed [15:0] qry [128];
    logic signed [15:0] cent [8];
    logic [7:0]         vcode [128];
    logic signed [31:0] acc [128];
    logic signed [31:0] run_max, run_sum;
    longint             dot;
    logic               seen;
    logic               kmode;
    logic [7:0]         hdim;
    logic [15:0]        sscale;

    localparam longint DOT_HI = 64'sd140737488355327;
    localparam longint DOT_LO = -DOT_HI - 1;

    function automatic longint fshift(longint x, int n);
        return x >>> n;
    endfunction

    function automatic logic signed [31:0] sat32(longint x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic longint exp_neg(longint x);
        longint ea, eb, e, r;
        int n, k;
        if (x < 0) x = 0;
        if ((x >> 16) >= 12) return 0;
        n = int'(x >> 16);
        k = int'((x >> 12) & 15);
        case (n)
            0: ea = 65536;  1: ea = 24109; 2: ea = 8869; 3: ea = 3263;
            4: ea = 1200;   5: ea = 442;   6: ea = 162;  7: ea = 60;
            8: ea = 22;     9: ea = 8;     10: ea = 3;   default: ea = 1;
        endcase
        case (k)
            0: eb = 65536;  1: eb = 61565;  2: eb = 57836;  3: eb = 54331;
            4: eb = 51039;  5: eb = 47947;  6: eb = 45042;  7: eb = 42313;
            8: eb = 39750;  9: eb = 37341;  10: eb = 35079; 11: eb = 32954;
            12: eb = 30957; 13: eb = 29081; 14: eb = 27319; default: eb = 25664;
        endcase
        e = (ea * eb) >> 16;
        r = x & 12'hfff;
        return e - ((e * r) >> 16);
    endfunction

    function automatic int eff_dim();
        if (hdim == 0) return 1;
        if (hdim > 128) return 128;
        return hdim;
    endfunction

    // fold a closed position into max, sum and accumulators
    task automatic close_position(longint norm, longint vs, longint vz);
        longint t, sc64, m_new, re, p, v, a;
        logic signed [31:0] score;
        int dim;
        dim = eff_dim();
        if (kmode) t = fshift(dot, 8);
        else       t = fshift(dot * norm, 16);
        sc64  = fshift(t * longint'(sscale), 16);
        score = sat32(sc64);
        if (!seen) begin
            m_new = score;
            re = 0;
        end else begin
            m_new = (score > run_max) ? score : run_max;
            re = exp_neg(m_new - longint'(run_max));
        end
        p = exp_neg(m_new - longint'(score));
        for (int d = 0; d < dim; d++) begin
            v = longint'(vcode[d]) * vs + vz;
            a = fshift(longint'(acc[d]) * re, 16) + fshift(p * v, 8);
            acc[d] = sat32(a);
        end
        run_sum = sat32(fshift(longint'(run_sum) * re, 16) + p);
        run_max = m_new[31:0];
        seen = 1'b1;
        dot = 0;
    endtask

    task automatic clear_softmax();
        for (int d = 0; d < 128; d++) acc[d] = 0;
        run_max = 32'sh80000000;
        run_sum = 0;
        dot = 0;
        seen = 1'b0;
    endtask

    task automatic take_word();
        int dim;
        longint s, key;
        read_word_t w;
        dim = eff_dim();
        case (s_command)
            CMD_LOAD_CENTROID: if (s_index < 8) cent[s_index] = s_data;
            CMD_LOAD_QUERY:    qry[s_index] = s_data;
            CMD_START:         clear_softmax();
            CMD_KV_ELEM: if (s_index < dim) begin
                key = kmode ? longint'(s_data) : longint'(cent[s_key_code[2:0]]);
                s = dot + longint'(qry[s_index]) * key;
                if (s > DOT_HI) s = DOT_HI;
                if (s < DOT_LO) s = DOT_LO;
                dot = s;
                vcode[s_index] = s_value_code;
                if (s_index == dim - 1)
                    close_position(longint'(s_key_norm), longint'(s_value_scale),
                                   longint'(s_value_zero));
            end
            CMD_READ_OUT: if (s_index < dim) begin
                w.idx = s_index;
                w.val = 0;
                if (seen && run_sum > 0)
                    w.val = sat32((longint'(acc[s_index]) * 65536) / longint'(run_sum));
                w.empty = !seen;
                read_q.push_back(w);
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        read_word_t w;
        if (!aresetn) begin
            clear_softmax();
            for (int d = 0; d < 128; d++) begin
                qry[d] = 0;
                vcode[d] = 0;
            end
            for (int c = 0; c < 8; c++) cent[c] = 0;
            kmode = 1'b0;
            hdim = HEAD_DIM_RST;
            sscale = SCORE_SCALE_RST;
            read_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_KEY_MODE:    kmode = cfg_wdata[0];
                    CFG_HEAD_DIM:    hdim = cfg_wdata[7:0];
                    CFG_SCORE_SCALE: sscale = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (read_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected read word idx=%0d value=%0d", $time,
                             m_out_index, m_out_value);
                end else begin
                    w = read_q.pop_front();
                    if (w.idx !== m_out_index || w.val !== m_out_value ||
                        w.empty !== m_empty_res) begin
                        fail_count++;
                        $display("%0t: read word: expected idx=%0d value=%0d empty=%0d, got idx=%0d value=%0d empty=%0d",
                                 $time, w.idx, w.val, w.empty,
                                 m_out_index, m_out_value, m_empty_res);
                    end
                end
            end
            if (s_valid && s_ready) take_word();
        end
        pending = read_q.size();
    end
endmodule

>>> tb/tb_quantized_kv_attention_decode.sv
// Testbench top for quantized_kv_attention_decode: drives config and input words,
// throttles the result channel, and reports the verdict. Depends on qkad_pkg,
// qkad_checker and the block itself.
module tb_quantized_kv_attention_decode;
    import qkad_pkg::*;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [15:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_command = '0;
    logic [6:0]         s_index = '0;
    logic signed [15:0] s_data = '0;
    logic [7:0]         s_key_code = '0;
    logic [7:0]         s_value_code = '0;
    logic [15:0]        s_key_norm = '0;
    logic signed [15:0] s_value_scale = '0;
    logic signed [15:0] s_value_zero = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [6:0]         m_out_index;
    logic signed [31:0] m_out_value;
    logic               m_empty_res;
    int                 fail_count;
    int                 pending;

    // idle knobs: percent chance per cycle; 0 gives a stretch with no idling
    int  send_idle_pct = 13;
    int  recv_idle_pct = 13;
    bit  recv_hold = 1'b0;
    bit  hold_done = 1'b0;
    int  cur_dim = 128;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    quantized_kv_attention_decode u_top (.*);

    qkad_checker u_chk (.*);

    // result side: random stalls, plus a long hold-off when asked
    always @(negedge aclk) begin
        if (recv_hold) m_ready <= 1'b0;
        else           m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        s_valid <= 1'b0;
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_HEAD_DIM)
            cur_dim = (val[7:0] == 0) ? 1 : (val[7:0] > 128 ? 128 : val[7:0]);
    endtask

    // offer one word and hold it until taken; called at a falling edge and
    // returns at the falling edge after the accept, valid still high
    task automatic send_word(cmd_t cmd, int idx, logic [15:0] data,
                             logic [7:0] kc, logic [7:0] vc, logic [15:0] kn,
                             logic [15:0] vs, logic [15:0] vz);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_index <= idx[6:0];
        s_data <= data;
        s_key_code <= kc;
        s_value_code <= vc;
        s_key_norm <= kn;
        s_value_scale <= vs;
        s_value_zero <= vz;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_simple(cmd_t cmd, int idx, logic [15:0] data);
        send_word(cmd, idx, data, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // wait for the checker to drain, then for a closing position to settle
    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (16 + 5 * 128 + 60) @(negedge aclk);
    endtask

    // load every query and centroid entry so no read hits an unwritten store
    task automatic load_all();
        for (int c = 0; c < 8; c++) send_simple(CMD_LOAD_CENTROID, c, $urandom);
        for (int d = 0; d < 128; d++) send_simple(CMD_LOAD_QUERY, d, $urandom);
    endtask

    // a full position with random content; scale kept moderate most of the time
    task automatic send_position();
        logic [15:0] kn, vs, vz;
        kn = $urandom;
        vs = ($urandom_range(3) == 0) ? $urandom : $urandom_range(511);
        vz = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1023) - 512;
        for (int d = 0; d < cur_dim; d++)
            send_word(CMD_KV_ELEM, d, $urandom, $urandom, $urandom, kn, vs, vz);
    endtask

    task automatic read_some(int n);
        for (int i = 0; i < n; i++)
            send_simple(CMD_READ_OUT, $urandom_range(cur_dim - 1), $urandom);
    endtask

    initial begin
        int words;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: head dim 4, every value code written before the position closes
        write_reg(CFG_HEAD_DIM, 8'd4);
        load_all();
        send_simple(CMD_START, 0, 0);
        send_simple(CMD_READ_OUT, 0, 0);           // empty read
        send_simple(CMD_READ_OUT, 100, 0);         // read beyond dim: no word
        send_simple(cmd_t'(3'd5), 0, 0);           // unknown commands
        send_simple(cmd_t'(3'd7), 0, 0);
        send_simple(CMD_LOAD_CENTROID, 120, 16'h7fff); // out of table: dropped
        send_word(CMD_KV_ELEM, 90, 16'h8000, 8'hff, 8'hff, 16'hffff, 16'h7fff, 16'h8000);
        send_word(CMD_KV_ELEM, 0, 16'h8000, 8'hff, 8'hff, 16'hffff, 16'h7fff, 16'h8000);
        send_word(CMD_KV_ELEM, 2, 16'h7fff, 8'h00, 8'h00, 16'hffff, 16'h8000, 16'h7fff);
        send_word(CMD_KV_ELEM, 1, 16'h0000, 8'h80, 8'h7f, 16'h0000, 16'h0000, 16'h0000);
        send_word(CMD_KV_ELEM, 3, 16'h7fff, 8'h07, 8'hff, 16'hffff, 16'h7fff, 16'h7fff);
        read_some(4);
        send_position();
        read_some(4);
        drain();

        words = 0;
        for (int phase = 0; phase < 8; phase++) begin
            // settings cycle through the extremes
            write_reg(CFG_KEY_MODE, phase[0]);
            case (phase % 4)
                0: write_reg(CFG_HEAD_DIM, 8'd1);
                1: write_reg(CFG_HEAD_DIM, $urandom_range(2, 12));
                2: write_reg(CFG_HEAD_DIM, (phase == 6) ? 8'd255 : 8'd128);
                default: write_reg(CFG_HEAD_DIM, 8'd0);
            endcase
            case (phase % 3)
                0: write_reg(CFG_SCORE_SCALE, 16'hffff);
                1: write_reg(CFG_SCORE_SCALE, 16'd0);
                default: write_reg(CFG_SCORE_SCALE, $urandom);
            endcase
            send_idle_pct = (phase == 2) ? 0 : 13;
            recv_idle_pct = (phase == 3) ? 0 : 13;
            if (phase == 4) begin
                load_all();
                words += 136;
            end
            // value codes must be written up to the dim before anything closes
            send_simple(CMD_START, 0, 0);
            send_position();
            words += 1 + cur_dim;
            while (words < (phase + 1) * 160) begin
                case ($urandom_range(9))
                    0: begin
                        send_simple(CMD_START, 0, 0);
                        words++;
                    end
                    1: begin
                        send_simple(cmd_t'($urandom_range(1, 0)), $urandom, $urandom);
                        words++;
                    end
                    2: begin
                        // stray element: may close a position early, still well defined
                        send_word(CMD_KV_ELEM, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom, $urandom);
                        words++;
                    end
                    3, 4, 5: begin
                        send_position();
                        words += cur_dim;
                    end
                    default: begin
                        read_some(4);
                        words += 4;
                    end
                endcase
                if (phase == 5 && words > phase * 160 + 60 && !hold_done) begin
                    // result side stalls while reads keep coming: block backs up
                    hold_done = 1'b1;
                    fork
                        begin
                            recv_hold = 1'b1;
                            repeat (400) @(negedge aclk);
                            recv_hold = 1'b0;
                        end
                    join_none
                    read_some(6);
                    words += 6;
                end
            end
            drain();
        end

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #40000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
